### rtl/core/tsdfr_pkg.sv
// ----------------------------------------------------------------------------
// tsdfr_pkg
// Shared types and constants of the transport-stream frame reassembler.
// ----------------------------------------------------------------------------
package tsdfr_pkg;

	localparam int unsigned PACKET_LEN_DEF = 188;
	localparam int unsigned HEADER_LEN     = 4;
	localparam int unsigned POS_W          = 8;
	localparam int unsigned PID_W          = 13;

	localparam logic [7:0]       SYNC_BYTE  = 8'h47;
	localparam logic [7:0]       STUFF_BYTE = 8'hff;
	localparam logic [PID_W-1:0] PID_RESET  = 13'h1ffe;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       byte_valid;
		logic       frame_end;
	} res_t;

endpackage

### rtl/core/tsdfr_out_reg.sv
// ----------------------------------------------------------------------------
// tsdfr_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module tsdfr_out_reg
	import tsdfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	input  res_t res,
	output logic res_ready,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic valid_q;
	res_t res_q;

	// Takes a new item when empty or when the held one leaves this cycle.
	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

endmodule

### rtl/core/tsdfr_pkt_ctrl.sv
// ----------------------------------------------------------------------------
// tsdfr_pkt_ctrl
// Input register, packet sync/header decode and frame reassembly state.
// ----------------------------------------------------------------------------
module tsdfr_pkt_ctrl
	import tsdfr_pkg::*;
#(
	parameter int unsigned PACKET_LEN = PACKET_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [PID_W-1:0] cfg_wdata,
	input  logic             in_valid,
	input  logic [7:0]       stream_byte,
	output logic             in_ready,
	output logic             res_valid,
	output res_t             res,
	input  logic             res_ready
);

	localparam logic [POS_W-1:0] PTR_LIM  = POS_W'(PACKET_LEN - HEADER_LEN - 1);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_LEN - 1);
	localparam logic [POS_W-1:0] HDR_POS  = POS_W'(HEADER_LEN);
	localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_TWO  = POS_W'(2);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [PID_W-1:0] target_pid_q;

	logic [POS_W-1:0] pos_q, pos_d;
	logic             in_pkt_q, in_pkt_d;
	logic [4:0]       pid_hi_q, pid_hi_d;
	logic             start_q, start_d;
	logic             sel_q, sel_d;
	logic [POS_W-1:0] left_q, left_d;
	logic             open_q, open_d;
	logic             skip_q, skip_d;

	logic             fire;
	logic [POS_W-1:0] ptr;
	logic [POS_W-1:0] left_dec;

	assign in_ready = !valid_s1 || res_ready;
	assign fire     = valid_s1 && res_ready;
	assign ptr      = (byte_s1 > PTR_LIM) ? PTR_LIM : byte_s1;
	assign left_dec = left_q - POS_ONE;

	always_comb begin
		pos_d     = pos_q;
		in_pkt_d  = in_pkt_q;
		pid_hi_d  = pid_hi_q;
		start_d   = start_q;
		sel_d     = sel_q;
		left_d    = left_q;
		open_d    = open_q;
		skip_d    = skip_q;
		res_valid = 1'b0;
		res       = '0;

		if (!in_pkt_q) begin
			if (byte_s1 == SYNC_BYTE) begin
				in_pkt_d = 1'b1;
				pos_d    = POS_ONE;
			end
		end else begin
			if (pos_q == POS_ONE) begin
				start_d  = byte_s1[6];
				pid_hi_d = byte_s1[4:0];
			end else if (pos_q == POS_TWO) begin
				sel_d = ({pid_hi_q, byte_s1} == target_pid_q);
			end else if (pos_q >= HDR_POS && sel_q) begin
				if (!start_q) begin
					if (open_q) begin
						res_valid      = 1'b1;
						res.frame_byte = byte_s1;
						res.byte_valid = 1'b1;
					end
				end else if (pos_q == HDR_POS) begin
					// pointer byte
					left_d = ptr;
					skip_d = 1'b1;
					if (ptr == '0 && open_q) begin
						res_valid     = 1'b1;
						res.frame_end = 1'b1;
						open_d        = 1'b0;
					end
				end else if (left_q != '0) begin
					left_d         = left_dec;
					res_valid      = 1'b1;
					res.frame_byte = byte_s1;
					res.byte_valid = 1'b1;
					if (left_dec == '0) begin
						res.frame_end = 1'b1;
						open_d        = 1'b0;
					end
				end else if (skip_q && byte_s1 == STUFF_BYTE) begin
					res_valid = 1'b0;
				end else begin
					skip_d         = 1'b0;
					open_d         = 1'b1;
					res_valid      = 1'b1;
					res.frame_byte = byte_s1;
					res.byte_valid = 1'b1;
				end
			end

			if (pos_q >= LAST_POS) begin
				in_pkt_d = 1'b0;
				pos_d    = '0;
			end else begin
				pos_d = pos_q + POS_ONE;
			end
		end

		if (!fire) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			target_pid_q <= PID_RESET;
			pos_q        <= '0;
			in_pkt_q     <= 1'b0;
			pid_hi_q     <= '0;
			start_q      <= 1'b0;
			sel_q        <= 1'b0;
			left_q       <= '0;
			open_q       <= 1'b0;
			skip_q       <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (cfg_we) begin
				target_pid_q <= cfg_wdata;
			end
			if (fire) begin
				pos_q    <= pos_d;
				in_pkt_q <= in_pkt_d;
				pid_hi_q <= pid_hi_d;
				start_q  <= start_d;
				sel_q    <= sel_d;
				left_q   <= left_d;
				open_q   <= open_d;
				skip_q   <= skip_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= stream_byte;
		end
	end

endmodule

### rtl/core/ts_docsis_frame_reassembler.sv
// ----------------------------------------------------------------------------
// ts_docsis_frame_reassembler
// Reassembles MAC frames from the transport-stream packets of one PID.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, stream_byte) takes one raw transport
//   stream byte per item. Output channel (out_valid/out_ready) gives at most
//   one result item per input item: frame_byte with byte_valid set, and
//   frame_end on the last byte of a frame or on an end-only item.
//   target_pid is written through cfg_we/cfg_wdata; the user must write it only
//   while the block is idle, which the block itself does not enforce.
// Path: input register, combinational decode, then the result register.
// Throughput: one byte per cycle while out_ready stays high; the per-byte
//   work is a position counter update plus a few compares between the input
//   and result registers.
// Reset: hunts for the 0x47 sync byte, no frame open, target_pid = 0x1ffe.
// Stall: the result register holds its item while out_ready is low; the
//   input register then holds one more byte and in_ready drops.
// ----------------------------------------------------------------------------
module ts_docsis_frame_reassembler
	import tsdfr_pkg::*;
#(
	parameter int unsigned PACKET_LEN = PACKET_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [PID_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       stream_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       frame_byte,
	output logic             byte_valid,
	output logic             frame_end
);

	logic res_valid;
	logic res_ready;
	res_t res;
	res_t out_res;

	tsdfr_pkt_ctrl #(
		.PACKET_LEN(PACKET_LEN)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.stream_byte(stream_byte),
		.in_ready   (in_ready),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready)
	);

	tsdfr_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(res_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

	assign frame_byte = out_res.frame_byte;
	assign byte_valid = out_res.byte_valid;
	assign frame_end  = out_res.frame_end;

endmodule

### test/ts_docsis_frame_reassembler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_docsis_frame_reassembler_tb
// Sends transport-stream packets into the reassembler and checks each frame
// item against a byte-level predictor kept in a small scoreboard class.
// Directed packets come first, then random packets under three PID settings,
// the first two with sender and receiver stalls.
// ----------------------------------------------------------------------------
module ts_docsis_frame_reassembler_tb;
	import tsdfr_pkg::*;

	localparam int MAX_PTR     = PACKET_LEN_DEF - HEADER_LEN - 1;
	localparam int PHASE_BYTES = 180;
	localparam int HOLD_CYCLES = 120;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [PID_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_ready;
	logic [7:0]       stream_byte;
	logic             out_valid;
	logic             out_ready;
	logic [7:0]       frame_byte;
	logic             byte_valid;
	logic             frame_end;

	class frame_tracker;
		logic [PID_W-1:0] pid_sel;
		logic [7:0]       pos;
		logic [4:0]       pid_hi;
		logic [7:0]       owed;
		bit               in_pkt;
		bit               pusi;
		bit               sel;
		bit               open;
		bit               skip_ff;
		res_t             pending_items[$];
		int               errors;
		int               n_data;
		int               n_ends;
		int               n_end_only;

		function new();
			pid_sel = PID_RESET;
			pos = '0;
			pid_hi = '0;
			owed = '0;
			in_pkt = 0;
			pusi = 0;
			sel = 0;
			open = 0;
			skip_ff = 0;
			errors = 0;
			n_data = 0;
			n_ends = 0;
			n_end_only = 0;
		endfunction

		function void set_pid(logic [PID_W-1:0] v);
			pid_sel = v;
		endfunction

		function int pending();
			return pending_items.size();
		endfunction

		function void push(logic [7:0] fb, bit bv, bit fe);
			res_t r;
			r.frame_byte = fb;
			r.byte_valid = bv;
			r.frame_end = fe;
			pending_items = {pending_items, r};
		endfunction

		// one accepted stream byte
		function void take_byte(logic [7:0] b);
			int p;
			if (!in_pkt) begin
				if (b == SYNC_BYTE) begin
					in_pkt = 1;
					pos = 8'd1;
				end
				return;
			end
			p = pos;
			if (p == 1) begin
				pusi = b[6];
				pid_hi = b[4:0];
			end else if (p == 2) begin
				sel = ({pid_hi, b} == pid_sel);
			end else if (p >= HEADER_LEN && sel) begin
				if (!pusi) begin
					if (open)
						push(b, 1'b1, 1'b0);
				end else if (p == HEADER_LEN) begin
					// pointer byte, saturated to what is left of the packet
					owed = (b > MAX_PTR) ? 8'(MAX_PTR) : b;
					skip_ff = 1;
					if (owed == 0 && open) begin
						push(8'h00, 1'b0, 1'b1);
						open = 0;
					end
				end else if (owed != 0) begin
					owed--;
					if (owed == 0) begin
						push(b, 1'b1, 1'b1);
						open = 0;
					end else begin
						push(b, 1'b1, 1'b0);
					end
				end else if (!(skip_ff && b == STUFF_BYTE)) begin
					skip_ff = 0;
					open = 1;
					push(b, 1'b1, 1'b0);
				end
			end
			if (p >= PACKET_LEN_DEF - 1) begin
				in_pkt = 0;
				pos = '0;
			end else begin
				pos = 8'(p + 1);
			end
		endfunction

		function void match_result(logic [7:0] fb, logic bv, logic fe);
			res_t e;
			if (pending_items.size() == 0) begin
				$error("unexpected item: frame_byte %02h byte_valid %0b frame_end %0b",
					fb, bv, fe);
				errors++;
				return;
			end
			e = pending_items.pop_front();
			if (fb !== e.frame_byte) begin
				$error("frame_byte: expected %02h, got %02h", e.frame_byte, fb);
				errors++;
			end
			if (bv !== e.byte_valid) begin
				$error("byte_valid: expected %0b, got %0b", e.byte_valid, bv);
				errors++;
			end
			if (fe !== e.frame_end) begin
				$error("frame_end: expected %0b, got %0b", e.frame_end, fe);
				errors++;
			end
			if (e.byte_valid)
				n_data++;
			else
				n_end_only++;
			if (e.frame_end)
				n_ends++;
		endfunction
	endclass

	frame_tracker tracker;
	logic [7:0]   tx_q[$];
	int           send_idle;
	int           recv_idle;
	int           hold_left;
	int           n_sent;
	int           n_packets;
	int           hold_reqs;

	ts_docsis_frame_reassembler dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.stream_byte (stream_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_byte  (frame_byte),
		.byte_valid  (byte_valid),
		.frame_end   (frame_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("ts_docsis_frame_reassembler regression: fail");
		$finish;
	end

	// result side: check, then pick ready for the next cycle
	initial begin
		int hold_seen;
		hold_seen = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.match_result(frame_byte, byte_valid, frame_end);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	function automatic void queue_byte(input logic [7:0] b);
		tx_q = {tx_q, b};
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle && gap < 20)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.take_byte(b);
		n_sent++;
	endtask

	task automatic flush_tx();
		while (tx_q.size() != 0)
			send_byte(tx_q.pop_front());
	endtask

	// for a pusi packet, pointer bytes owed, then n_ff stuffing bytes (or stuffing to the end)
	function automatic void add_packet(input bit pusi, input logic [PID_W-1:0] pid,
			input int ptr, input int n_ff, input bit all_ff);
		int eff;
		int k;
		logic [7:0] hb;
		eff = (ptr > MAX_PTR) ? MAX_PTR : ptr;
		hb = 8'($urandom);
		hb[6] = pusi;
		hb[4:0] = pid[12:8];
		queue_byte(SYNC_BYTE);
		queue_byte(hb);
		queue_byte(pid[7:0]);
		queue_byte(8'($urandom));
		for (int i = HEADER_LEN; i < PACKET_LEN_DEF; i++) begin
			k = i - HEADER_LEN - 1;
			if (!pusi)
				queue_byte(8'($urandom));
			else if (i == HEADER_LEN)
				queue_byte(8'(ptr));
			else if (k < eff)
				queue_byte(8'($urandom));
			else if (all_ff || k < eff + n_ff)
				queue_byte(STUFF_BYTE);
			else
				queue_byte(8'($urandom));
		end
		n_packets++;
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_pid(input logic [PID_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_pid(v);
	endtask

	task automatic random_phase(input int s_idle, input int r_idle);
		int start;
		int ptr;
		bit pusi;
		logic [PID_W-1:0] pid;
		send_idle = s_idle;
		recv_idle = r_idle;
		start = n_sent;
		while (n_sent - start < PHASE_BYTES) begin
			// junk between packets forces a resync
			if ($urandom_range(99) < 10)
				repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
			pid = tracker.pid_sel;
			if ($urandom_range(99) < 20)
				pid = $urandom_range(1) ? PID_W'($urandom)
					: pid ^ (13'd1 << $urandom_range(PID_W - 1));
			pusi = ($urandom_range(99) < 55);
			case ($urandom_range(3))
				0: ptr = 0;
				1: ptr = $urandom_range(1, 12);
				2: ptr = $urandom_range(150, MAX_PTR);
				default: ptr = $urandom_range(MAX_PTR + 1, 255);
			endcase
			add_packet(pusi, pid, ptr, $urandom_range(0, 4), $urandom_range(99) < 8);
			// cut packet: the next header lands inside the count
			if ($urandom_range(99) < 8)
				repeat ($urandom_range(1, 150)) void'(tx_q.pop_back());
			flush_tx();
		end
		settle();
	endtask

	initial begin
		tracker = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		stream_byte <= '0;
		send_idle = 32;
		recv_idle = 46;
		hold_reqs = 0;
		n_sent = 0;
		n_packets = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset PID, with one packet on another PID
		queue_byte(8'h00);
		queue_byte(8'hff);
		queue_byte(8'h46);
		queue_byte(8'h48);
		add_packet(1'b1, PID_RESET, 5, 3, 1'b0);   // tail of a frame never opened
		flush_tx();
		hold_reqs++;                                // long stall on the result side
		add_packet(1'b0, PID_RESET, 0, 0, 1'b0);
		flush_tx();
		add_packet(1'b0, 13'h1fff, 0, 0, 1'b0);
		add_packet(1'b1, PID_RESET, 0, 0, 1'b1);   // end-only, then all stuffing
		add_packet(1'b1, PID_RESET, 0, 2, 1'b0);   // zero pointer with no frame open
		add_packet(1'b1, PID_RESET, 255, 0, 1'b0); // saturated pointer
		add_packet(1'b0, PID_RESET, 0, 0, 1'b0);   // continuation with no frame open
		flush_tx();
		settle();

		write_pid(13'h0000);
		random_phase(32, 46);
		write_pid(13'h1fff);
		random_phase(46, 32);
		write_pid(PID_W'($urandom));
		random_phase(0, 0);

		$display("Run: %0d stream bytes, %0d packets, PIDs reset/0x0000/0x1fff/random,",
			n_sent, n_packets);
		$display("  %0d frame bytes and %0d frame ends (%0d end-only) checked under stalls",
			tracker.n_data, tracker.n_ends, tracker.n_end_only);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("ts_docsis_frame_reassembler regression: pass");
		else
			$display("ts_docsis_frame_reassembler regression: fail");
		$finish;
	end

endmodule

### files.f
rtl/core/tsdfr_pkg.sv
rtl/core/tsdfr_out_reg.sv
rtl/core/tsdfr_pkt_ctrl.sv
rtl/core/ts_docsis_frame_reassembler.sv
test/ts_docsis_frame_reassembler_tb.sv
